/* rtl/core/xpf_pkg.sv */
// xpf_pkg: shared types and constants for the xor pair parity fec encoder
// used by xpf_cell, xpf_ctrl and xor_pair_parity_fec_encoder_top; no dependencies
package xpf_pkg;

  localparam int WORD_W            = 32;
  localparam int PAYLOAD_WORDS_DEF = 40;
  localparam logic [WORD_W-1:0] PARITY_FLAG = 32'h8000_0000;

  // per-beat control broadcast to every cell of the payload chain
  typedef struct packed {
    logic load;   // header beat: working copy takes the stored previous payload
    logic shift;  // payload beat: working and current lines move one cell to the head
    logic swap;   // last payload beat: current payload becomes the previous one
  } xpf_cell_ctl_t;

  typedef struct packed {
    logic              fwd_valid;
    logic [WORD_W-1:0] fwd_word;
    logic              fwd_last;
    logic              fec_valid;
    logic [WORD_W-1:0] fec_word;
    logic              fec_last;
    logic              discard;
  } xpf_result_t;

endpackage

/* rtl/core/xor_pair_parity_fec_encoder_top.sv */
// Packet words stream in one per cycle while the output is not stalled, and each
// accepted beat gives one result beat in the next cycle, carrying the forwarded word
// and, for odd sequence numbers, the parity word (header with bit 31 set, then
// previous full payload XOR current payload). Throughput is one word per clock
// unless out_ready holds the single output register full; input ready follows
// output ready when that register is full. The previous payload sits in a chain of
// PAYLOAD_WORDS cells that shifts towards cell 0 on each payload beat; reset clears it.
// Depends on xpf_pkg, xpf_cell and xpf_ctrl.
module xor_pair_parity_fec_encoder_top #(
  parameter int PAYLOAD_WORDS = xpf_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [xpf_pkg::WORD_W-1:0] word,
  input  logic                       end_of_packet,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       fwd_valid,
  output logic [xpf_pkg::WORD_W-1:0] fwd_word,
  output logic                       fwd_last,
  output logic                       fec_valid,
  output logic [xpf_pkg::WORD_W-1:0] fec_word,
  output logic                       fec_last,
  output logic                       discard
);
  import xpf_pkg::*;

  xpf_cell_ctl_t     ctl;
  xpf_result_t       result;
  logic [WORD_W-1:0] work_q [PAYLOAD_WORDS];
  logic [WORD_W-1:0] cur_q  [PAYLOAD_WORDS];

  xpf_ctrl #(
    .PAYLOAD_WORDS(PAYLOAD_WORDS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .word         (word),
    .end_of_packet(end_of_packet),
    .prev_head    (work_q[0]),
    .ctl          (ctl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result       (result)
  );

  for (genvar k = 0; k < PAYLOAD_WORDS; k++) begin : g_cell
    logic [WORD_W-1:0] work_in, cur_in;
    if (k == PAYLOAD_WORDS - 1) begin : g_tail
      // the incoming word enters at the tail of the chain
      assign work_in = '0;
      assign cur_in  = word;
    end else begin : g_mid
      assign work_in = work_q[k+1];
      assign cur_in  = cur_q[k+1];
    end
    xpf_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .work_in(work_in),
      .cur_in (cur_in),
      .work   (work_q[k]),
      .cur    (cur_q[k])
    );
  end

  assign fwd_valid = result.fwd_valid;
  assign fwd_word  = result.fwd_word;
  assign fwd_last  = result.fwd_last;
  assign fec_valid = result.fec_valid;
  assign fec_word  = result.fec_word;
  assign fec_last  = result.fec_last;
  assign discard   = result.discard;

`ifndef SYNTHESIS
  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted beat gave no result");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_fec_with_fwd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fec_valid) |-> fwd_valid)
    else $error("parity word without forwarded word");

  a_discard_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && discard) |-> (fwd_last && (fec_last == fec_valid)))
    else $error("discard not on final beat");

  a_header_parity: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && ctl.load && word[0]) |=> (fec_valid && fec_word[31]))
    else $error("odd header without parity header");
`endif

endmodule

/* rtl/core/xpf_cell.sv */
// xpf_cell: one payload word slot of the chain (previous, working and current word)
// depends on xpf_pkg
module xpf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  xpf_pkg::xpf_cell_ctl_t     ctl,
  input  logic [xpf_pkg::WORD_W-1:0] work_in,
  input  logic [xpf_pkg::WORD_W-1:0] cur_in,
  output logic [xpf_pkg::WORD_W-1:0] work,
  output logic [xpf_pkg::WORD_W-1:0] cur
);
  import xpf_pkg::*;

  logic [WORD_W-1:0] prev;

  // previous full payload, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (ctl.swap) begin
      prev <= cur_in;
    end
  end

  // working copy walks to the head so the matching previous word is always at cell 0
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= prev;
    end else if (ctl.shift) begin
      work <= work_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      cur <= cur_in;
    end
  end

endmodule

/* rtl/core/xpf_ctrl.sv */
// xpf_ctrl: word position tracking, parity word forming and the output register
// depends on xpf_pkg
module xpf_ctrl #(
  parameter int PAYLOAD_WORDS = xpf_pkg::PAYLOAD_WORDS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [xpf_pkg::WORD_W-1:0] word,
  input  logic                       end_of_packet,
  input  logic [xpf_pkg::WORD_W-1:0] prev_head,
  output xpf_pkg::xpf_cell_ctl_t     ctl,
  output logic                       out_valid,
  input  logic                       out_ready,
  output xpf_pkg::xpf_result_t       result
);
  import xpf_pkg::*;

  localparam int PW = $clog2(PAYLOAD_WORDS + 2);
  localparam logic [PW-1:0] LAST_POS = PW'(PAYLOAD_WORDS);

  logic [PW-1:0] pos, pos_next;
  logic          odd;
  logic          beat, at_hdr, at_pay, at_last, at_ovf, odd_eff;
  xpf_result_t   res_next;

  assign beat    = in_valid & in_ready;
  assign in_ready = ~out_valid | out_ready;
  assign at_hdr  = (pos == '0);
  assign at_last = (pos == LAST_POS);
  assign at_pay  = ~at_hdr & (pos <= LAST_POS);
  assign at_ovf  = ~at_hdr & ~at_pay;
  assign odd_eff = at_hdr ? word[0] : odd;

  assign ctl.load  = beat & at_hdr;
  assign ctl.shift = beat & at_pay;
  assign ctl.swap  = beat & at_last;

  // once past the last payload word the position sticks until end of packet
  assign pos_next = end_of_packet ? '0 : (at_ovf ? pos : pos + PW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      odd <= 1'b0;
    end else if (beat) begin
      pos <= pos_next;
      if (at_hdr) begin
        odd <= word[0];
      end
    end
  end

  always_comb begin
    res_next.fwd_valid = at_hdr | at_pay;
    res_next.fwd_word  = res_next.fwd_valid ? word : '0;
    res_next.fwd_last  = (at_hdr & end_of_packet) | (at_pay & (at_last | end_of_packet));
    res_next.fec_valid = res_next.fwd_valid & odd_eff;
    if (!res_next.fec_valid) begin
      res_next.fec_word = '0;
    end else if (at_hdr) begin
      res_next.fec_word = word | PARITY_FLAG;
    end else begin
      res_next.fec_word = prev_head ^ word;
    end
    res_next.fec_last  = res_next.fwd_last & odd_eff;
    res_next.discard   = (at_hdr | (at_pay & ~at_last)) & end_of_packet;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      result <= res_next;
    end
  end

endmodule

/* test/xor_pair_parity_fec_encoder_top_tb.sv */
// Testbench for xor_pair_parity_fec_encoder_top: queued packet beats, a predictor
// of the forwarded and parity streams, and a scoreboard on the result beats.
// Depends on xpf_pkg and the encoder RTL.
module xor_pair_parity_fec_encoder_top_tb;
  import xpf_pkg::*;

  localparam int PW          = PAYLOAD_WORDS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_BEATS  = 650;

  typedef struct {
    logic [WORD_W-1:0] w;
    logic              eop;
    bit                drain_first;  // sender waits until all results are back
  } pkt_beat_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] word = '0;
  logic              end_of_packet = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              fwd_valid;
  logic [WORD_W-1:0] fwd_word;
  logic              fwd_last;
  logic              fec_valid;
  logic [WORD_W-1:0] fec_word;
  logic              fec_last;
  logic              discard;

  xor_pair_parity_fec_encoder_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .word(word), .end_of_packet(end_of_packet),
    .out_valid(out_valid), .out_ready(out_ready),
    .fwd_valid(fwd_valid), .fwd_word(fwd_word), .fwd_last(fwd_last),
    .fec_valid(fec_valid), .fec_word(fec_word), .fec_last(fec_last),
    .discard(discard)
  );

  always #10 clk = ~clk;

  // predictor state
  int                word_pos = 0;
  logic              odd_seq = 1'b0;
  logic              prev_bank = 1'b0;
  logic [WORD_W-1:0] pay_bank [2][PW];

  pkt_beat_t   beat_queue[$];
  xpf_result_t expected_results[$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          beat_taken = 1'b0;
  int          gap_left = 0;
  int          burst_left = 1;
  rx_mode_t    rx_mode = RX_OPEN;

  function automatic xpf_result_t encode_beat(logic [WORD_W-1:0] w, logic eop);
    xpf_result_t r;
    int idx;
    r = '0;
    if (word_pos == 0) begin
      odd_seq     = w[0];
      r.fwd_valid = 1'b1;
      r.fwd_word  = w;
      r.fec_valid = odd_seq;
      r.fec_word  = odd_seq ? (w | PARITY_FLAG) : '0;
      if (eop) begin
        r.fwd_last = 1'b1;
        r.fec_last = odd_seq;
        r.discard  = 1'b1;
      end else begin
        word_pos = 1;
      end
    end else if (word_pos <= PW) begin
      idx         = word_pos - 1;
      r.fwd_valid = 1'b1;
      r.fwd_word  = w;
      r.fec_valid = odd_seq;
      r.fec_word  = odd_seq ? (pay_bank[prev_bank][idx] ^ w) : '0;
      pay_bank[!prev_bank][idx] = w;
      if (word_pos == PW) begin
        r.fwd_last = 1'b1;
        r.fec_last = odd_seq;
        prev_bank  = !prev_bank;
        word_pos   = eop ? 0 : PW + 1;
      end else if (eop) begin
        // short packet: previous bank kept, no swap
        r.fwd_last = 1'b1;
        r.fec_last = odd_seq;
        r.discard  = 1'b1;
        word_pos   = 0;
      end else begin
        word_pos = word_pos + 1;
      end
    end else begin
      // truncated tail, the result beat carries all zeros
      word_pos = eop ? 0 : PW + 1;
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic push_beat(logic [WORD_W-1:0] w, logic eop, bit drain_first);
    pkt_beat_t b;
    b.w = w;
    b.eop = eop;
    b.drain_first = drain_first;
    beat_queue.push_back(b);
  endtask

  // header plus payload, end of packet on the final beat
  task automatic push_packet(int len, bit drain_first);
    push_beat($urandom, len == 1, drain_first);
    for (int i = 1; i < len; i++) push_beat(pick_word(), i == len - 1, 1'b0);
  endtask

  initial begin
    int kind;
    int n;
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < PW; i++) pay_bank[b][i] = '0;

    // single-beat packets, even and odd, at the word extremes
    push_beat(32'h0000_0000, 1'b1, 1'b0);
    push_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
    // short odd packet
    push_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_beat(32'h0000_0000, 1'b0, 1'b0);
    push_beat(32'hFFFF_FFFF, 1'b1, 1'b0);
    // short even packet whose header already has bit 31 set
    push_beat(32'h8000_0000, 1'b0, 1'b1);
    push_beat(32'hAAAA_AAAA, 1'b0, 1'b0);
    push_beat(32'h5555_5555, 1'b1, 1'b0);
    // two-beat odd packet then a new odd single
    push_beat(32'h0000_0001, 1'b0, 1'b0);
    push_beat(32'h1234_5678, 1'b1, 1'b0);
    push_beat(32'h8000_0001, 1'b1, 1'b0);

    push_packet(PW + 1, 1'b1);
    while (beat_queue.size() < RAND_BEATS) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        push_packet(PW + 1, $urandom_range(0, 9) == 0);
      end else if (kind < 72) begin
        // overlong: tail beats are dropped, eop on the last of them
        push_packet(PW + 1 + $urandom_range(1, 4), 1'b0);
      end else if (kind < 90) begin
        push_packet($urandom_range(1, PW), 1'b0);
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          push_beat($urandom, (i == n - 1) || ($urandom_range(0, 2) == 0), 1'b0);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beat_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // sender: bursts of beats with random gaps
  always @(negedge clk) begin
    logic              v_n;
    logic [WORD_W-1:0] w_n;
    logic              e_n;
    pkt_beat_t         nb;
    v_n = in_valid;
    w_n = word;
    e_n = end_of_packet;
    if (!rst && (!in_valid || beat_taken)) begin
      v_n = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (beat_queue.size() != 0 &&
                   !(beat_queue[0].drain_first && expected_results.size() != 0)) begin
        nb  = beat_queue.pop_front();
        v_n = 1'b1;
        w_n = nb.w;
        e_n = nb.eop;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
    beat_taken = 1'b0;
    in_valid      <= v_n;
    word          <= w_n;
    end_of_packet <= e_n;
  end

  // receiver stall pattern, with a randomly chosen mode
  always @(negedge clk) begin
    logic ready_n;
    if (cycle_count % 96 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   ready_n = 1'b1;
      RX_RANDOM: ready_n = ($urandom_range(0, 3) != 0);
      RX_SPARSE: ready_n = (cycle_count % 8 == 0);
      default:   ready_n = (cycle_count % 3 != 2);
    endcase
    out_ready <= ready_n;
  end

  // scoreboard
  always @(posedge clk) begin
    xpf_result_t got;
    xpf_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(encode_beat(word, end_of_packet));
        beat_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = {fwd_valid, fwd_word, fwd_last, fec_valid, fec_word, fec_last, discard};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("result beat with nothing expected at cycle %0d: %p", cycle_count, got);
        end else begin
          want = expected_results.pop_front();
          if (got.fwd_valid !== want.fwd_valid || got.fwd_word !== want.fwd_word ||
              got.fwd_last !== want.fwd_last || got.fec_valid !== want.fec_valid ||
              got.fec_word !== want.fec_word || got.fec_last !== want.fec_last ||
              got.discard !== want.discard) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at cycle %0d\n  expected %p\n  actual   %p",
                       cycle_count, want, got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
